FILE: hw/rtl/skrt_pkg.sv
// Shared constants and types of the sorted key record table.
`timescale 1ns / 1ps

package skrt_pkg;

	localparam int CAPACITY = 32;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int OUT_CNT_W = 6;
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	localparam logic [2:0] OP_INSERT = 3'd0;
	localparam logic [2:0] OP_DELETE = 3'd1;
	localparam logic [2:0] OP_CONTAINS = 3'd2;
	localparam logic [2:0] OP_UPDATE = 3'd3;
	localparam logic [2:0] OP_READ = 3'd4;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_MISS = 2'd2;
	localparam logic [1:0] ST_DUP = 2'd3;

	localparam int REC_W = 96;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] salary;
		logic [31:0] title;
	} rec_t;

	typedef struct packed {
		logic we;
		logic [IDX_W-1:0] waddr;
		logic [IDX_W-1:0] raddr;
		rec_t wdata;
	} mem_req_t;

	typedef struct packed {
		logic [1:0] status;
		logic found;
		logic [31:0] salary;
		logic [31:0] title;
		logic [CNT_W-1:0] count;
	} res_t;

endpackage

FILE: hw/rtl/skrt_ram.sv
// Generic simple dual-port RAM with a registered read.
`timescale 1ns / 1ps

module skrt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/skrt_seq.sv
// Sequencer that scans, shifts and rewrites the record memory for one request.
`timescale 1ns / 1ps

module skrt_seq (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [2:0] operation,
	input logic signed [31:0] key,
	input logic [31:0] salary_word,
	input logic [31:0] title_word,
	output skrt_pkg::mem_req_t mem,
	input skrt_pkg::rec_t rdata,
	output logic res_valid,
	input logic res_take,
	output skrt_pkg::res_t res
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_FETCH = 7'b0000010,
		S_CMP = 7'b0000100,
		S_DECIDE = 7'b0001000,
		S_SHIFT = 7'b0010000,
		S_PLACE = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t state_q;
	logic [skrt_pkg::CNT_W-1:0] count_q;
	logic rd_active_q;
	logic wr_pend_q;

	logic [2:0] op_q;
	logic signed [31:0] key_q;
	logic [31:0] sw_q;
	logic [31:0] tw_q;
	logic [skrt_pkg::CNT_W-1:0] idx_q;
	logic [skrt_pkg::CNT_W-1:0] pos_q;
	logic [skrt_pkg::CNT_W-1:0] rd_ptr_q;
	logic [skrt_pkg::IDX_W-1:0] wr_addr_q;
	logic found_q;
	logic [31:0] sal_q;
	logic [31:0] tit_q;
	logic [1:0] status_q;

	logic key_hit;
	logic key_gt;
	logic shift_up;
	logic rd_last;
	logic scan_end;
	logic dec_shrink;
	logic [1:0] dec_status;
	state_t dec_state;

	assign in_stall = (state_q != S_IDLE);
	assign key_hit = (rdata.key == key_q);
	assign key_gt = ($signed(rdata.key) > key_q);
	assign shift_up = (op_q == skrt_pkg::OP_INSERT);
	assign scan_end = (idx_q == count_q);
	assign rd_last = shift_up ? (rd_ptr_q == pos_q) : (rd_ptr_q == count_q - 1'b1);
	assign dec_shrink = (op_q == skrt_pkg::OP_DELETE) && found_q && (pos_q + 1'b1 == count_q);

	always_comb begin
		dec_status = skrt_pkg::ST_DONE;
		dec_state = S_DONE;
		case (op_q)
			skrt_pkg::OP_INSERT: begin
				if (count_q >= skrt_pkg::CAP_CNT) begin
					dec_status = skrt_pkg::ST_FULL;
				end else if (found_q) begin
					dec_status = skrt_pkg::ST_DUP;
				end else if (pos_q == count_q) begin
					dec_state = S_PLACE;
				end else begin
					dec_state = S_SHIFT;
				end
			end
			skrt_pkg::OP_DELETE: begin
				if (!found_q) begin
					dec_status = skrt_pkg::ST_MISS;
				end else if (!dec_shrink) begin
					dec_state = S_SHIFT;
				end
			end
			skrt_pkg::OP_CONTAINS, skrt_pkg::OP_READ: begin
				if (!found_q) begin
					dec_status = skrt_pkg::ST_MISS;
				end
			end
			skrt_pkg::OP_UPDATE: begin
				if (!found_q) begin
					dec_status = skrt_pkg::ST_MISS;
				end else begin
					dec_state = S_PLACE;
				end
			end
			default: begin
				dec_status = skrt_pkg::ST_DONE;
			end
		endcase
	end

	always_comb begin
		mem.raddr = (state_q == S_FETCH) ? idx_q[skrt_pkg::IDX_W-1:0]
			: rd_ptr_q[skrt_pkg::IDX_W-1:0];
		mem.we = ((state_q == S_SHIFT) && wr_pend_q) || (state_q == S_PLACE);
		if (state_q == S_PLACE) begin
			mem.waddr = pos_q[skrt_pkg::IDX_W-1:0];
			mem.wdata.key = key_q;
			mem.wdata.salary = sw_q;
			mem.wdata.title = tw_q;
		end else begin
			mem.waddr = wr_addr_q;
			mem.wdata = rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rd_active_q <= 1'b0;
			wr_pend_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					state_q <= scan_end ? S_DECIDE : S_CMP;
				end
				S_CMP: begin
					state_q <= (key_hit || key_gt) ? S_DECIDE : S_FETCH;
				end
				S_DECIDE: begin
					state_q <= dec_state;
					rd_active_q <= 1'b1;
					wr_pend_q <= 1'b0;
					if (dec_shrink) begin
						count_q <= count_q - 1'b1;
					end
				end
				S_SHIFT: begin
					rd_active_q <= rd_active_q && !rd_last;
					wr_pend_q <= rd_active_q;
					if (!rd_active_q && wr_pend_q) begin
						if (shift_up) begin
							state_q <= S_PLACE;
						end else begin
							count_q <= count_q - 1'b1;
							state_q <= S_DONE;
						end
					end
				end
				S_PLACE: begin
					if (shift_up) begin
						count_q <= count_q + 1'b1;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q <= operation;
				key_q <= key;
				sw_q <= salary_word;
				tw_q <= title_word;
				idx_q <= '0;
				found_q <= 1'b0;
			end
			S_FETCH: begin
				if (scan_end) begin
					pos_q <= count_q;
				end
			end
			S_CMP: begin
				if (key_hit) begin
					found_q <= 1'b1;
					pos_q <= idx_q;
					sal_q <= rdata.salary;
					tit_q <= rdata.title;
				end else if (key_gt) begin
					pos_q <= idx_q;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
			S_DECIDE: begin
				status_q <= dec_status;
				rd_ptr_q <= shift_up ? count_q - 1'b1 : pos_q + 1'b1;
			end
			S_SHIFT: begin
				if (rd_active_q) begin
					wr_addr_q <= shift_up ? skrt_pkg::IDX_W'(rd_ptr_q + 1'b1)
						: skrt_pkg::IDX_W'(rd_ptr_q - 1'b1);
					if (!rd_last) begin
						rd_ptr_q <= shift_up ? rd_ptr_q - 1'b1 : rd_ptr_q + 1'b1;
					end
				end
			end
			default: begin
				status_q <= status_q;
			end
		endcase
	end

	assign res_valid = (state_q == S_DONE);
	assign res.status = status_q;
	assign res.found = (op_q <= skrt_pkg::OP_READ) && found_q;
	assign res.salary = ((op_q == skrt_pkg::OP_READ) && found_q) ? sal_q : 32'd0;
	assign res.title = ((op_q == skrt_pkg::OP_READ) && found_q) ? tit_q : 32'd0;
	assign res.count = count_q;

endmodule

FILE: hw/rtl/sorted_key_record_table.sv
// Top level of the sorted key record table: memory, sequencer and result register.
`timescale 1ns / 1ps

// The table holds up to 32 records in ascending order of a signed key, each with
// two payload words. A request arrives on the input channel (in_valid, in_stall)
// with an operation, a key and two payload words; every request gives exactly one
// result on the output channel (out_valid, out_stall).
// Records live in one synchronous memory with a registered read. A request first
// scans from the lowest entry, each entry in a fetch and a compare state, until
// it meets its key or a larger one. An insert then moves each later entry up,
// and a delete moves each later entry down, one entry per cycle; an insert or an
// update ends with one write of the record. A result comes soonest on an empty
// table and takes longest when the scan passes all 32 records of a full table.
// The next request can be taken in the cycle after the result leaves the
// sequencer. Requests are served one at a time; in_stall stays high from
// acceptance until the result has been passed to the output register.
// The output register lets the next request be taken while a result still waits
// to be collected; while out_stall is high the result holds.
// Reset empties the table at once and clears both channels; no clearing pass is
// needed, as only entries below the record count are ever used.

module sorted_key_record_table (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [2:0] operation,
	input logic signed [31:0] key,
	input logic [31:0] salary_word,
	input logic [31:0] title_word,
	output logic out_valid,
	input logic out_stall,
	output logic [1:0] status,
	output logic found,
	output logic [31:0] salary_out,
	output logic [31:0] title_out,
	output logic [skrt_pkg::OUT_CNT_W-1:0] entry_count
);

	skrt_pkg::mem_req_t mem;
	skrt_pkg::rec_t rdata;
	skrt_pkg::res_t res;
	logic res_valid;
	logic res_take;
	logic out_valid_q;
	skrt_pkg::res_t out_q;

	skrt_ram #(
		.WIDTH(skrt_pkg::REC_W),
		.DEPTH(skrt_pkg::CAPACITY)
	) u_ram (
		.clk(clk),
		.we(mem.we),
		.waddr(mem.waddr),
		.wdata(mem.wdata),
		.raddr(mem.raddr),
		.rdata(rdata)
	);

	skrt_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.key(key),
		.salary_word(salary_word),
		.title_word(title_word),
		.mem(mem),
		.rdata(rdata),
		.res_valid(res_valid),
		.res_take(res_take),
		.res(res)
	);

	assign res_take = res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_q.status;
	assign found = out_q.found;
	assign salary_out = out_q.salary;
	assign title_out = out_q.title;
	assign entry_count = skrt_pkg::OUT_CNT_W'(out_q.count);

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		res.count <= skrt_pkg::CAP_CNT)
		else $error("Record count exceeds the table capacity.");

	assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !mem.we)
		else $error("Memory written while no request is in progress.");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_take && (res.status == skrt_pkg::ST_FULL) |-> res.count == skrt_pkg::CAP_CNT)
		else $error("Table reported full below capacity.");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_take && (res.status == skrt_pkg::ST_MISS) |-> !res.found)
		else $error("Missing key reported as found.");
`endif

endmodule

FILE: verif/sorted_key_record_table_test.sv
// Self-checking testbench of the sorted key record table, with its own table predictor.
`timescale 1ns / 1ps

module sorted_key_record_table_test;

	localparam int HALF_PERIOD = 2;
	localparam int LIMIT_CYCLES = 800000;
	localparam int DRAIN_CYCLES = 120;
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int POOL_SIZE = 48;
	localparam int PRINT_LIMIT = 40;
	localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [2:0] OP_SPARE_LAST = 3'd7;
	localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		logic [1:0] status;
		logic found;
		logic [31:0] salary;
		logic [31:0] title;
		logic [skrt_pkg::OUT_CNT_W-1:0] count;
	} table_reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] operation = skrt_pkg::OP_INSERT;
	logic signed [31:0] key = '0;
	logic [31:0] salary_word = '0;
	logic [31:0] title_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic found;
	logic [31:0] salary_out;
	logic [31:0] title_out;
	logic [skrt_pkg::OUT_CNT_W-1:0] entry_count;

	logic signed [31:0] held_key [skrt_pkg::CAPACITY];
	logic [31:0] held_salary [skrt_pkg::CAPACITY];
	logic [31:0] held_title [skrt_pkg::CAPACITY];
	int held_count = 0;
	logic signed [31:0] key_pool [POOL_SIZE];

	table_reply_t expected_replies [$];
	table_reply_t wanted_reply;

	int sender_idle_pct = 0;
	int receiver_idle_pct = 0;
	int hold_request = 0;
	int hold_left = 0;
	int cycle_count = 0;
	int mismatches = 0;
	int requests_sent = 0;
	int replies_checked = 0;
	int full_rejects = 0;
	int peak_count = 0;

	sorted_key_record_table i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.key(key),
		.salary_word(salary_word),
		.title_word(title_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.found(found),
		.salary_out(salary_out),
		.title_out(title_out),
		.entry_count(entry_count)
	);

	always #(HALF_PERIOD) clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	function automatic table_reply_t apply_request(input logic [2:0] op,
			input logic signed [31:0] k, input logic [31:0] sw, input logic [31:0] tw);
		table_reply_t r;
		int hit;
		int slot;
		r = '0;
		hit = held_count;
		for (int i = held_count - 1; i >= 0; i--) begin
			if (held_key[i] == k) hit = i;
		end
		if (op <= skrt_pkg::OP_READ) r.found = (hit < held_count);
		case (op)
			skrt_pkg::OP_INSERT: begin
				if (held_count >= skrt_pkg::CAPACITY) begin
					r.status = skrt_pkg::ST_FULL;
					full_rejects++;
				end else if (r.found) begin
					r.status = skrt_pkg::ST_DUP;
				end else begin
					slot = 0;
					while (slot < held_count && held_key[slot] < k) slot++;
					for (int i = held_count; i > slot; i--) begin
						held_key[i] = held_key[i - 1];
						held_salary[i] = held_salary[i - 1];
						held_title[i] = held_title[i - 1];
					end
					held_key[slot] = k;
					held_salary[slot] = sw;
					held_title[slot] = tw;
					held_count++;
					if (held_count > peak_count) peak_count = held_count;
				end
			end
			skrt_pkg::OP_DELETE: begin
				if (!r.found) begin
					r.status = skrt_pkg::ST_MISS;
				end else begin
					for (int i = hit; i + 1 < held_count; i++) begin
						held_key[i] = held_key[i + 1];
						held_salary[i] = held_salary[i + 1];
						held_title[i] = held_title[i + 1];
					end
					held_count--;
				end
			end
			skrt_pkg::OP_CONTAINS: begin
				if (!r.found) r.status = skrt_pkg::ST_MISS;
			end
			skrt_pkg::OP_UPDATE: begin
				if (!r.found) begin
					r.status = skrt_pkg::ST_MISS;
				end else begin
					held_salary[hit] = sw;
					held_title[hit] = tw;
				end
			end
			skrt_pkg::OP_READ: begin
				if (!r.found) begin
					r.status = skrt_pkg::ST_MISS;
				end else begin
					r.salary = held_salary[hit];
					r.title = held_title[hit];
				end
			end
			default: begin
			end
		endcase
		r.count = skrt_pkg::OUT_CNT_W'(held_count);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] wanted);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("%0t ns: %s is %0h, should be %0h", $time, what, got, wanted);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_replies.size() == 0) begin
				report_mismatch("result with no request outstanding, status", status,
					skrt_pkg::ST_DONE);
			end else begin
				wanted_reply = expected_replies.pop_front();
				replies_checked++;
				if (status !== wanted_reply.status)
					report_mismatch("status", status, wanted_reply.status);
				if (found !== wanted_reply.found)
					report_mismatch("found", found, wanted_reply.found);
				if (salary_out !== wanted_reply.salary)
					report_mismatch("salary_out", salary_out, wanted_reply.salary);
				if (title_out !== wanted_reply.title)
					report_mismatch("title_out", title_out, wanted_reply.title);
				if (entry_count !== wanted_reply.count)
					report_mismatch("entry_count", entry_count, wanted_reply.count);
			end
		end
	end

	// The receiver stalls at random, or for a counted stretch when one is requested.
	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
		end
	end

	task automatic send_request(input logic [2:0] op, input logic signed [31:0] k,
			input logic [31:0] sw, input logic [31:0] tw);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		key <= k;
		salary_word <= sw;
		title_word <= tw;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_replies.push_back(apply_request(op, k, sw, tw));
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic send_random_request(input int insert_pct, input int delete_pct);
		int roll;
		logic [2:0] op;
		logic signed [31:0] k;
		roll = $urandom_range(0, 99);
		if (roll < 5) begin
			op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
		end else if (roll < 5 + insert_pct) begin
			op = skrt_pkg::OP_INSERT;
		end else if (roll < 5 + insert_pct + delete_pct) begin
			op = skrt_pkg::OP_DELETE;
		end else begin
			case (roll % 3)
				0: op = skrt_pkg::OP_CONTAINS;
				1: op = skrt_pkg::OP_UPDATE;
				default: op = skrt_pkg::OP_READ;
			endcase
		end
		if (op != skrt_pkg::OP_INSERT && held_count > 0 && $urandom_range(0, 99) < 60)
			k = held_key[$urandom_range(0, held_count - 1)];
		else if ($urandom_range(0, 99) < 85)
			k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
		else
			k = $urandom;
		send_request(op, k, $urandom, $urandom);
	endtask

	task automatic fill_key_pool();
		key_pool[0] = KEY_MIN;
		key_pool[1] = KEY_MAX;
		key_pool[2] = 32'sd0;
		key_pool[3] = -32'sd1;
		for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
	endtask

	task automatic test_directed_cases();
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		send_request(skrt_pkg::OP_CONTAINS, 32'sd0, '0, '0);
		send_request(skrt_pkg::OP_READ, 32'sd5, '1, '1);
		send_request(skrt_pkg::OP_UPDATE, 32'sd7, '1, '0);
		send_request(skrt_pkg::OP_DELETE, -32'sd1, '0, '0);
		send_request(skrt_pkg::OP_INSERT, KEY_MIN, '1, '0);
		send_request(skrt_pkg::OP_INSERT, KEY_MAX, '0, '1);
		send_request(skrt_pkg::OP_INSERT, 32'sd0, 32'h1234_5678, 32'h9abc_def0);
		send_request(skrt_pkg::OP_INSERT, -32'sd1, 32'h5555_5555, 32'haaaa_aaaa);
		send_request(skrt_pkg::OP_INSERT, 32'sd1, 32'haaaa_aaaa, 32'h5555_5555);
		send_request(skrt_pkg::OP_INSERT, KEY_MIN, '0, '1);
		send_request(skrt_pkg::OP_READ, KEY_MIN, '0, '0);
		send_request(skrt_pkg::OP_READ, KEY_MAX, '0, '0);
		send_request(skrt_pkg::OP_UPDATE, 32'sd0, '1, '1);
		send_request(skrt_pkg::OP_READ, 32'sd0, '0, '0);
		send_request(skrt_pkg::OP_CONTAINS, 32'sd1, '0, '0);
		send_request(skrt_pkg::OP_DELETE, KEY_MIN, '0, '0);
		send_request(skrt_pkg::OP_DELETE, KEY_MAX, '0, '0);
		send_request(skrt_pkg::OP_DELETE, 32'sd0, '0, '0);
		send_request(skrt_pkg::OP_READ, 32'sd0, '0, '0);
		send_request(OP_SPARE_FIRST, -32'sd1, '1, '1);
		send_request(OP_SPARE_FIRST + 3'd1, -32'sd1, '1, '1);
		send_request(OP_SPARE_LAST, 32'sd1, '1, '1);
		send_request(skrt_pkg::OP_CONTAINS, -32'sd1, '0, '0);
	endtask

	task automatic test_full_table();
		sender_idle_pct = 30;
		receiver_idle_pct = 30;
		while (held_count < skrt_pkg::CAPACITY)
			send_request(skrt_pkg::OP_INSERT, $urandom, $urandom, $urandom);
		send_request(skrt_pkg::OP_INSERT, $urandom, $urandom, $urandom);
		send_request(skrt_pkg::OP_INSERT, held_key[0], $urandom, $urandom);
		send_request(skrt_pkg::OP_UPDATE, held_key[skrt_pkg::CAPACITY / 2], $urandom, $urandom);
		send_request(skrt_pkg::OP_READ, held_key[skrt_pkg::CAPACITY / 2], '0, '0);
		send_request(skrt_pkg::OP_READ, held_key[skrt_pkg::CAPACITY - 1], '0, '0);
		send_request(skrt_pkg::OP_DELETE, held_key[skrt_pkg::CAPACITY - 1], '0, '0);
		send_request(skrt_pkg::OP_INSERT, KEY_MAX, '1, '1);
		while (held_count > 0)
			send_request(skrt_pkg::OP_DELETE, held_key[$urandom_range(0, held_count - 1)],
				'0, '0);
	endtask

	task automatic test_output_hold_off();
		sender_idle_pct = 0;
		receiver_idle_pct = 20;
		fill_key_pool();
		hold_request = HOLD_OFF_CYCLES;
		repeat (12) send_random_request(50, 15);
	endtask

	task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
			input int requests);
		sender_idle_pct = sender_pct;
		receiver_idle_pct = receiver_pct;
		fill_key_pool();
		// Alternate filling and draining so that both the full and the empty table recur.
		for (int n = 0; n < requests; n++) begin
			if ((n / 80) % 2 == 0)
				send_random_request(50, 15);
			else
				send_random_request(15, 50);
		end
	endtask

	initial begin : watchdog
		while (cycle_count < LIMIT_CYCLES) @(posedge clk);
		$display("Run stopped after %0d cycles without finishing.", cycle_count);
		$display("sorted_key_record_table: mismatch");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_full_table();
		test_output_hold_off();
		test_random_traffic(15, 87, 390);
		test_random_traffic(87, 15, 390);
		test_random_traffic(0, 0, 390);
		in_valid <= 1'b0;
		while (expected_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d requests with %0d results checked, all five operations",
			requests_sent, replies_checked);
		$display("and spare codes; table reached %0d records, %0d inserts refused as full.",
			peak_count, full_rejects);
		if (mismatches == 0) begin
			$display("sorted_key_record_table: match");
		end else begin
			$display("%0d mismatches found.", mismatches);
			$display("sorted_key_record_table: mismatch");
		end
		$finish;
	end

endmodule
